// File: src/vpf_pkg.sv
// ---------------------------------------------------------------------------
// vpf_pkg: shared types and arithmetic of the velocity PID step
// Q16.16 types, register map, multiplier request and saturating helpers.
// ---------------------------------------------------------------------------
package vpf_pkg;

	localparam int QW       = 32;
	localparam int REG_W    = 31;
	localparam int ADDR_W   = 5;
	localparam int MUL_W    = QW + 1;
	localparam int PROD_W   = 2 * MUL_W;

	typedef logic signed [QW-1:0]     q_t;
	typedef logic [REG_W-1:0]         ureg_t;
	typedef logic signed [MUL_W-1:0]  mop_t;
	typedef logic signed [PROD_W-1:0] prod_t;

	localparam q_t Q_MAX          = 32'sh7FFF_FFFF;
	localparam q_t Q_MIN          = 32'sh8000_0000;
	localparam q_t W_OLD          = 32'sd58982;
	localparam q_t W_NEW          = 32'sd6554;
	localparam q_t KICK_THRESHOLD = 32'sd1310;
	localparam prod_t Q_HALF      = 66'sd32768;

	localparam ureg_t VEL_SCALE_RST   = 31'd65536;
	localparam ureg_t DRIVE_LIMIT_RST = 31'h7FFF_FFFF;

	typedef enum logic [2:0] {
		REG_VEL_SCALE,
		REG_KP_GAIN,
		REG_KI_DT,
		REG_KD_OVER_DT,
		REG_KA_OVER_DT,
		REG_KICK_LEVEL,
		REG_DRIVE_LIMIT,
		REG_WINDUP_LIMIT
	} reg_idx_t;

	typedef struct packed {
		ureg_t vel_scale;
		ureg_t kp_gain;
		ureg_t ki_dt;
		ureg_t kd_over_dt;
		ureg_t ka_over_dt;
		ureg_t kick_level;
		ureg_t drive_limit;
		ureg_t windup_limit;
	} cfg_t;

	typedef struct packed {
		mop_t a;
		mop_t b;
	} mul_req_t;

	function automatic mop_t sx(input q_t x);
		return $signed({x[QW-1], x});
	endfunction

	function automatic mop_t zx(input ureg_t u);
		return $signed({2'b00, u});
	endfunction

	function automatic q_t sat33(input logic [QW:0] s);
		if (s[QW] != s[QW-1]) begin
			return s[QW] ? Q_MIN : Q_MAX;
		end
		return $signed(s[QW-1:0]);
	endfunction

	function automatic q_t add_sat(input q_t a, input q_t b);
		return sat33({a[QW-1], a} + {b[QW-1], b});
	endfunction

	function automatic q_t sub_sat(input q_t a, input q_t b);
		return sat33({a[QW-1], a} - {b[QW-1], b});
	endfunction

	function automatic q_t clamp_sym(input q_t v, input ureg_t lim_u);
		q_t lim;
		q_t r;
		lim = $signed({1'b0, lim_u});
		r = v;
		if (r > lim) begin
			r = lim;
		end
		if (r < -lim) begin
			r = -lim;
		end
		return r;
	endfunction

endpackage

// File: src/vpf_if.sv
// ---------------------------------------------------------------------------
// vpf_in_if / vpf_out_if: valid-ready channels of the velocity PID step
// Input carries the three velocities, output carries the drive value.
// ---------------------------------------------------------------------------
interface vpf_in_if;
	import vpf_pkg::*;
	logic valid;
	logic ready;
	q_t   measured_velocity;
	q_t   setpoint_velocity;
	q_t   target_velocity;
	modport source (output valid, output measured_velocity, output setpoint_velocity,
		output target_velocity, input ready);
	modport sink (input valid, input measured_velocity, input setpoint_velocity,
		input target_velocity, output ready);
endinterface

interface vpf_out_if;
	import vpf_pkg::*;
	logic valid;
	logic ready;
	q_t   drive;
	modport source (output valid, output drive, input ready);
	modport sink (input valid, input drive, output ready);
endinterface

// File: src/vpf_regs.sv
// ---------------------------------------------------------------------------
// vpf_regs: APB register file
// Eight 31-bit gain and limit registers at word addresses, read back on prdata.
// ---------------------------------------------------------------------------
module vpf_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [vpf_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	output vpf_pkg::cfg_t              cfg
);
	import vpf_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	ureg_t    rd_val;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.vel_scale    <= VEL_SCALE_RST;
			cfg_q.kp_gain      <= '0;
			cfg_q.ki_dt        <= '0;
			cfg_q.kd_over_dt   <= '0;
			cfg_q.ka_over_dt   <= '0;
			cfg_q.kick_level   <= '0;
			cfg_q.drive_limit  <= DRIVE_LIMIT_RST;
			cfg_q.windup_limit <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_VEL_SCALE:    cfg_q.vel_scale    <= pwdata[REG_W-1:0];
				REG_KP_GAIN:      cfg_q.kp_gain      <= pwdata[REG_W-1:0];
				REG_KI_DT:        cfg_q.ki_dt        <= pwdata[REG_W-1:0];
				REG_KD_OVER_DT:   cfg_q.kd_over_dt   <= pwdata[REG_W-1:0];
				REG_KA_OVER_DT:   cfg_q.ka_over_dt   <= pwdata[REG_W-1:0];
				REG_KICK_LEVEL:   cfg_q.kick_level   <= pwdata[REG_W-1:0];
				REG_DRIVE_LIMIT:  cfg_q.drive_limit  <= pwdata[REG_W-1:0];
				REG_WINDUP_LIMIT: cfg_q.windup_limit <= pwdata[REG_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_VEL_SCALE:    rd_val = cfg_q.vel_scale;
			REG_KP_GAIN:      rd_val = cfg_q.kp_gain;
			REG_KI_DT:        rd_val = cfg_q.ki_dt;
			REG_KD_OVER_DT:   rd_val = cfg_q.kd_over_dt;
			REG_KA_OVER_DT:   rd_val = cfg_q.ka_over_dt;
			REG_KICK_LEVEL:   rd_val = cfg_q.kick_level;
			REG_DRIVE_LIMIT:  rd_val = cfg_q.drive_limit;
			REG_WINDUP_LIMIT: rd_val = cfg_q.windup_limit;
		endcase
	end

	assign prdata = {1'b0, rd_val};

endmodule

// File: src/vpf_mul.sv
// ---------------------------------------------------------------------------
// vpf_mul: shared Q16.16 multiplier
// Registered 33x33 product; result rounded half up and saturated combinationally from it.
// ---------------------------------------------------------------------------
module vpf_mul (
	input  logic              clk,
	input  vpf_pkg::mul_req_t req,
	output vpf_pkg::q_t       res
);
	import vpf_pkg::*;

	prod_t prod_s1;
	prod_t rnd;
	logic  ovf;

	always_ff @(posedge clk) begin
		prod_s1 <= req.a * req.b;
	end

	assign rnd = prod_s1 + Q_HALF;
	assign ovf = !((&rnd[PROD_W-1:47]) || !(|rnd[PROD_W-1:47]));
	assign res = ovf ? (rnd[PROD_W-1] ? Q_MIN : Q_MAX) : $signed(rnd[47:16]);

endmodule

// File: src/vpf_seq.sv
// ---------------------------------------------------------------------------
// vpf_seq: step sequencer of the velocity PID
// Drives the shared multiplier through the error, PID, filter and feedforward
// terms, holds the loop state and the output register.
// ---------------------------------------------------------------------------
module vpf_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  vpf_pkg::cfg_t     cfg,
	vpf_in_if.sink            in_ch,
	vpf_out_if.source         out_ch,
	output vpf_pkg::mul_req_t mul_req,
	input  vpf_pkg::q_t       mul_res
);
	import vpf_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_LIN, S_ERR, S_P, S_I, S_D, S_DW, S_F, S_FD, S_SUM
	} state_t;

	state_t state_q;
	q_t meas_q, setp_q, targ_q;
	q_t err_q, dtarg_q, de_q, rawd_q, fdo_q, p_q, ff_q;
	q_t integ_q, prev_err_q, fd_q, prev_targ_q;
	q_t drive_q;
	logic out_valid_q;
	logic load_out;

	q_t integ_nxt;
	logic signed [QW+2:0] sum;
	logic signed [QW+2:0] kick;
	q_t sum_sat;

	assign in_ch.ready  = (state_q == S_IDLE);
	assign out_ch.valid = out_valid_q;
	assign out_ch.drive = drive_q;
	assign load_out     = (state_q == S_SUM) && (!out_valid_q || out_ch.ready);

	always_comb begin
		unique case (state_q)
			S_LIN:   mul_req = '{a: sx(meas_q),  b: zx(cfg.vel_scale)};
			S_ERR:   mul_req = '{a: sx(fd_q),    b: sx(W_OLD)};
			S_P:     mul_req = '{a: zx(cfg.kp_gain),    b: sx(err_q)};
			S_I:     mul_req = '{a: zx(cfg.ki_dt),      b: sx(err_q)};
			S_D:     mul_req = '{a: zx(cfg.kd_over_dt), b: sx(de_q)};
			S_DW:    mul_req = '{a: sx(dtarg_q), b: zx(cfg.ka_over_dt)};
			S_F:     mul_req = '{a: sx(rawd_q),  b: sx(W_NEW)};
			default: mul_req = '0;
		endcase
	end

	always_comb begin
		integ_nxt = add_sat(integ_q, mul_res);
		if (cfg.windup_limit != '0) begin
			integ_nxt = clamp_sym(integ_nxt, cfg.windup_limit);
		end else begin
			integ_nxt = '0;
		end
	end

	always_comb begin
		if (targ_q > KICK_THRESHOLD) begin
			kick = $signed({4'b0000, cfg.kick_level});
		end else if (targ_q < -KICK_THRESHOLD) begin
			kick = -$signed({4'b0000, cfg.kick_level});
		end else begin
			kick = '0;
		end
		sum = $signed({{3{p_q[QW-1]}}, p_q}) + $signed({{3{integ_q[QW-1]}}, integ_q})
			+ $signed({{3{fd_q[QW-1]}}, fd_q}) + $signed({{3{ff_q[QW-1]}}, ff_q}) + kick;
		if (!((&sum[QW+2:QW-1]) || !(|sum[QW+2:QW-1]))) begin
			sum_sat = sum[QW+2] ? Q_MIN : Q_MAX;
		end else begin
			sum_sat = sum[QW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			integ_q     <= '0;
			prev_err_q  <= '0;
			fd_q        <= '0;
			prev_targ_q <= '0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_ch.valid) begin
						meas_q  <= in_ch.measured_velocity;
						setp_q  <= in_ch.setpoint_velocity;
						targ_q  <= in_ch.target_velocity;
						state_q <= S_LIN;
					end
				end
				S_LIN: state_q <= S_ERR;
				S_ERR: begin
					err_q       <= sub_sat(setp_q, mul_res);
					dtarg_q     <= sub_sat(targ_q, prev_targ_q);
					prev_targ_q <= targ_q;
					state_q     <= S_P;
				end
				S_P: begin
					fdo_q   <= mul_res;
					state_q <= S_I;
				end
				S_I: begin
					p_q        <= mul_res;
					de_q       <= sub_sat(err_q, prev_err_q);
					prev_err_q <= err_q;
					state_q    <= S_D;
				end
				S_D: begin
					integ_q <= integ_nxt;
					state_q <= S_DW;
				end
				S_DW: begin
					rawd_q  <= mul_res;
					state_q <= S_F;
				end
				S_F: begin
					ff_q    <= mul_res;
					state_q <= S_FD;
				end
				S_FD: begin
					fd_q    <= add_sat(fdo_q, mul_res);
					state_q <= S_SUM;
				end
				S_SUM: begin
					if (load_out) begin
						drive_q <= clamp_sym(sum_sat, cfg.drive_limit);
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: src/velocity_pid_feedforward_step.sv
// ---------------------------------------------------------------------------
// velocity_pid_feedforward_step: velocity loop step with feedforward
// Scaled error, clamped integral, filtered derivative, acceleration
// feedforward and stiction kick, summed and clamped to the drive limit.
// ---------------------------------------------------------------------------
// One drive value per input transfer, velocities and drive signed Q16.16. An
// item passes S_LIN, S_ERR, S_P, S_I, S_D, S_DW, S_F, S_FD and S_SUM from its
// input transfer to its result being loaded into the output register; the
// input is not ready during that time and the next item is taken in S_IDLE,
// so no new item is accepted before the last is through. The seven products
// go in turn through the single registered multiplier, each read back in the
// state after its issue, followed by the final sum.
// A finished result waits in the output register while the next item is
// taken; a result not yet taken holds the last step of the next item.
module velocity_pid_feedforward_step (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [vpf_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	vpf_in_if.sink                     in_ch,
	vpf_out_if.source                  out_ch
);
	import vpf_pkg::*;

	cfg_t     cfg;
	mul_req_t mul_req;
	q_t       mul_res;
	q_t       drive_lim;

	vpf_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	vpf_mul u_mul (
		.clk (clk),
		.req (mul_req),
		.res (mul_res)
	);

	vpf_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.mul_req (mul_req),
		.mul_res (mul_res)
	);

	assign drive_lim = $signed({1'b0, cfg.drive_limit});

`ifndef ASSERT_OFF
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready |=> !in_ch.ready)
		else $error("input ready right after a transfer");

	a_drive_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> (out_ch.drive <= drive_lim && out_ch.drive >= -drive_lim))
		else $error("drive outside limit");

	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_ch.valid) |-> !$past(in_ch.ready))
		else $error("result appeared without an item in work");
`endif

endmodule
